/* sv/a2b_pkg.sv */
// Shared types, codes and constants for the AVCC to Annex B converter.
package a2b_pkg;

  localparam int unsigned PARAM_STORE_BYTES_DEF = 56;

  // Result status codes
  localparam logic [2:0] ST_OK          = 3'd0;
  localparam logic [2:0] ST_EXTRA_TRUNC = 3'd1;
  localparam logic [2:0] ST_OVERFLOW    = 3'd2;
  localparam logic [2:0] ST_BAD_LEN     = 3'd3;
  localparam logic [2:0] ST_PKT_TRUNC   = 3'd4;

  localparam logic [4:0] NAL_TYPE_IDR = 5'd5;
  localparam logic [4:0] COUNT_MASK   = 5'h1F;

  typedef enum logic [2:0] {
    SP_SKIP    = 3'd0,
    SP_LENSIZE = 3'd1,
    SP_COUNT   = 3'd2,
    SP_LEN_HI  = 3'd3,
    SP_LEN_LO  = 3'd4,
    SP_UNIT    = 3'd5,
    SP_DONE    = 3'd6,
    SP_ERROR   = 3'd7
  } setup_phase_e;

  typedef enum logic [1:0] {
    PP_LENGTH  = 2'd0,
    PP_NAL     = 2'd1,
    PP_DISCARD = 2'd2
  } pkt_phase_e;

  typedef enum logic [2:0] {
    ES_IDLE  = 3'd0,
    ES_PARAM = 3'd1,
    ES_SC0   = 3'd2,
    ES_SC1   = 3'd3,
    ES_SC2   = 3'd4,
    ES_DATA  = 3'd5,
    ES_TRUNC = 3'd6
  } emit_state_e;

  // Extradata parser status toward the top level
  typedef struct packed {
    logic       has_status;
    logic [2:0] status;
    logic       param_ready;
    logic       busy;
  } setup_stat_t;

  // Packet parser verdict for the byte just taken
  typedef struct packed {
    logic       status_only;
    logic [2:0] status;
    logic       emit;
    logic       first;
    logic       trunc;
  } pkt_res_t;

endpackage

/* sv/a2b_ram.sv */
// Generic single-write, single-read synchronous RAM with registered read data.
module a2b_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 56
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* sv/a2b_setup.sv */
// Extradata parser: walks the decoder config record and fills the parameter-set store.
module a2b_setup #(
  parameter int unsigned PARAM_STORE_BYTES = a2b_pkg::PARAM_STORE_BYTES_DEF
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 fire_i,
  input  logic [7:0]                           byte_i,
  input  logic                                 last_i,
  output logic                                 wr_en_o,
  output logic [$clog2(PARAM_STORE_BYTES)-1:0] wr_addr_o,
  output logic [7:0]                           wr_data_o,
  output logic [$clog2(PARAM_STORE_BYTES+1)-1:0] plen_o,
  output a2b_pkg::setup_stat_t                 stat_o
);
  import a2b_pkg::*;

  localparam int unsigned AW = $clog2(PARAM_STORE_BYTES);
  localparam int unsigned LW = $clog2(PARAM_STORE_BYTES + 1);
  localparam int unsigned SW = 18;

  setup_phase_e phase_q, phase_d;
  logic [2:0]   skip_q, skip_d;
  logic [4:0]   units_q, units_d;
  logic [15:0]  ubl_q, ubl_d;
  logic         pps_q, pps_d;
  logic [LW-1:0] plen_q, plen_d;
  logic         ready_q, ready_d;
  logic [1:0]   pre_q, pre_d;     // start-code bytes still to write

  logic         adv;
  logic [4:0]   ucnt;
  logic [LW-1:0] pre_addr;
  logic [SW-1:0] need;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= SP_SKIP;
      skip_q  <= '0;
      units_q <= '0;
      ubl_q   <= '0;
      pps_q   <= 1'b0;
      plen_q  <= '0;
      ready_q <= 1'b0;
      pre_q   <= '0;
    end else begin
      phase_q <= phase_d;
      skip_q  <= skip_d;
      units_q <= units_d;
      ubl_q   <= ubl_d;
      pps_q   <= pps_d;
      plen_q  <= plen_d;
      ready_q <= ready_d;
      pre_q   <= pre_d;
    end
  end

  assign pre_addr = plen_q - LW'(pre_q);
  assign need     = SW'(plen_q) + SW'(4) + SW'({ubl_q[15:8], byte_i});

  always_comb begin
    phase_d   = phase_q;
    skip_d    = skip_q;
    units_d   = units_q;
    ubl_d     = ubl_q;
    pps_d     = pps_q;
    plen_d    = plen_q;
    ready_d   = ready_q;
    pre_d     = pre_q;
    wr_en_o   = 1'b0;
    wr_addr_o = plen_q[AW-1:0];
    wr_data_o = byte_i;
    stat_o.has_status  = 1'b0;
    stat_o.status      = ST_OK;
    stat_o.param_ready = ready_q;
    stat_o.busy        = (pre_q != 2'd0);
    adv  = 1'b0;
    ucnt = units_q - 5'd1;

    // trailing start-code bytes after a unit length
    if (pre_q != 2'd0) begin
      wr_en_o   = 1'b1;
      wr_addr_o = pre_addr[AW-1:0];
      wr_data_o = (pre_q == 2'd1) ? 8'h01 : 8'h00;
      pre_d     = pre_q - 2'd1;
    end

    if (fire_i) begin
      case (phase_q)
        SP_SKIP: begin
          if (skip_q == 3'd0) begin
            plen_d  = '0;
            ready_d = 1'b0;
          end
          skip_d = skip_q + 3'd1;
          if (skip_q == 3'd3) begin
            skip_d  = '0;
            phase_d = SP_LENSIZE;
          end
        end
        SP_LENSIZE: begin
          pps_d   = 1'b0;
          phase_d = SP_COUNT;
        end
        SP_COUNT: begin
          ucnt = byte_i[4:0] & COUNT_MASK;
          adv  = 1'b1;
        end
        SP_LEN_HI: begin
          ubl_d   = {byte_i, 8'h00};
          phase_d = SP_LEN_LO;
        end
        SP_LEN_LO: begin
          ubl_d = {ubl_q[15:8], byte_i};
          if (need > SW'(PARAM_STORE_BYTES)) begin
            plen_d  = '0;
            ready_d = 1'b0;
            phase_d = SP_ERROR;
            stat_o.has_status = 1'b1;
            stat_o.status     = ST_OVERFLOW;
          end else begin
            wr_en_o   = 1'b1;
            wr_addr_o = plen_q[AW-1:0];
            wr_data_o = 8'h00;
            plen_d    = plen_q + LW'(4);
            pre_d     = 2'd3;
            if (ubl_d == 16'd0) begin
              adv = 1'b1;
            end else begin
              phase_d = SP_UNIT;
            end
          end
        end
        SP_UNIT: begin
          if (plen_q < LW'(PARAM_STORE_BYTES)) begin
            wr_en_o = 1'b1;
            plen_d  = plen_q + LW'(1);
          end
          ubl_d = ubl_q - 16'd1;
          if (ubl_d == 16'd0) begin
            adv = 1'b1;
          end
        end
        default: begin
        end
      endcase

      if (adv) begin
        units_d = ucnt;
        if (ucnt != 5'd0) begin
          phase_d = SP_LEN_HI;
        end else if (pps_q) begin
          phase_d = SP_DONE;
          ready_d = 1'b1;
        end else begin
          pps_d   = 1'b1;
          phase_d = SP_COUNT;
        end
      end

      if (last_i) begin
        if (phase_d != SP_DONE && phase_d != SP_ERROR) begin
          plen_d  = '0;
          ready_d = 1'b0;
          pre_d   = '0;
          stat_o.has_status = 1'b1;
          stat_o.status     = ST_EXTRA_TRUNC;
        end
        phase_d = SP_SKIP;
        skip_d  = '0;
      end
    end
  end

  assign plen_o = plen_q;

endmodule

/* sv/a2b_pkt.sv */
// Packet parser: tracks 4-byte NAL lengths and classifies each packet byte.
module a2b_pkt (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              fire_i,
  input  logic [7:0]        byte_i,
  input  logic              last_i,
  output a2b_pkg::pkt_res_t res_o
);
  import a2b_pkg::*;

  pkt_phase_e  phase_q, phase_d;
  logic [1:0]  pfx_q, pfx_d;
  logic [31:0] len_q, len_d;
  logic [31:0] left_q, left_d;
  logic [31:0] len_new;
  logic [31:0] left_dec;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PP_LENGTH;
      pfx_q   <= '0;
      len_q   <= '0;
      left_q  <= '0;
    end else begin
      phase_q <= phase_d;
      pfx_q   <= pfx_d;
      len_q   <= len_d;
      left_q  <= left_d;
    end
  end

  assign len_new  = {len_q[23:0], byte_i};
  assign left_dec = left_q - 32'd1;

  always_comb begin
    phase_d = phase_q;
    pfx_d   = pfx_q;
    len_d   = len_q;
    left_d  = left_q;
    res_o   = '0;
    res_o.status = ST_OK;

    if (fire_i) begin
      case (phase_q)
        PP_LENGTH: begin
          len_d = len_new;
          if (pfx_q != 2'd3) begin
            pfx_d = pfx_q + 2'd1;
            if (last_i) begin
              res_o.status_only = 1'b1;
              res_o.status      = ST_PKT_TRUNC;
              pfx_d = '0;
              len_d = '0;
            end
          end else begin
            pfx_d = '0;
            if (len_new == 32'd0) begin
              res_o.status_only = 1'b1;
              res_o.status      = ST_BAD_LEN;
              len_d = '0;
              if (!last_i) begin
                phase_d = PP_DISCARD;
              end
            end else if (last_i) begin
              res_o.status_only = 1'b1;
              res_o.status      = ST_PKT_TRUNC;
              len_d = '0;
            end else begin
              left_d  = len_new;
              phase_d = PP_NAL;
            end
          end
        end
        PP_NAL: begin
          res_o.emit  = 1'b1;
          res_o.first = (left_q == len_q);
          left_d      = left_dec;
          if (left_dec == 32'd0 || last_i) begin
            res_o.trunc = (left_dec != 32'd0);
            phase_d = PP_LENGTH;
            pfx_d   = '0;
            len_d   = '0;
            left_d  = '0;
          end
        end
        default: begin
          if (last_i) begin
            phase_d = PP_LENGTH;
            pfx_d   = '0;
            len_d   = '0;
            left_d  = '0;
          end
        end
      endcase
    end
  end

endmodule

/* sv/avcc_to_annexb_converter_core.sv */
// Top level: stream ports, result register and the output burst sequencer.
//
// Converts H.264 length-prefixed (AVCC) input to start-code (Annex B) output, one byte per
// input transfer. tuser selects the byte's kind: 0 = codec extradata, 1 = packet data; tlast
// marks the last byte of the extradata block or of the packet. The extradata parser keeps
// the SPS/PPS units, each behind a 00 00 00 01 start code, in a PARAM_STORE_BYTES-entry
// single-port-write RAM; the store is not cleared after reset and needs no clearing pass,
// since only bytes written by the current extradata block are ever replayed. Each NAL of a
// packet comes out as 00 00 01 plus its bytes; an IDR NAL is preceded by the stored
// parameter sets once a block has parsed cleanly. Errors come out as status-only transfers
// (tuser[0] = 0) and tlast on the output marks the last transfer caused by one input byte.
// Flow: the low byte of a unit length in extradata holds the input while the rest of the
// start code is written one byte per cycle through the RAM write port. The first byte of
// a NAL holds it while the start code, preceded on an IDR by the stored bytes (read one
// byte per cycle unless stalled), goes out; an early packet end adds a truncation status.
// A stalled output holds the input off through the single result register.
module avcc_to_annexb_converter_core #(
  parameter int unsigned PARAM_STORE_BYTES = a2b_pkg::PARAM_STORE_BYTES_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       s_axis_tvalid,
  output logic       s_axis_tready,
  input  logic [7:0] s_axis_tdata,   // [7:0] data_byte
  input  logic       s_axis_tuser,   // [0] func
  input  logic       s_axis_tlast,   // last_byte
  output logic       m_axis_tvalid,
  input  logic       m_axis_tready,
  output logic [7:0] m_axis_tdata,   // [7:0] out_byte
  output logic [3:0] m_axis_tuser,   // [0] byte_valid, [3:1] status
  output logic       m_axis_tlast    // run_last
);
  import a2b_pkg::*;

  localparam int unsigned AW = $clog2(PARAM_STORE_BYTES);
  localparam int unsigned LW = $clog2(PARAM_STORE_BYTES + 1);

  // Input side
  logic        s_fire;
  logic        slot_free;

  // Store write/read
  logic          wr_en;
  logic [AW-1:0] wr_addr;
  logic [7:0]    wr_data;
  logic          rd_en;
  logic [AW-1:0] rd_addr;
  logic [7:0]    rd_data;
  logic [LW-1:0] plen;

  setup_stat_t setup_stat;
  pkt_res_t    pkt_res;

  // Burst sequencer
  emit_state_e   state_q, state_d;
  logic [AW-1:0] idx_q, idx_d;
  logic [LW-1:0] idx_nxt;
  logic [7:0]    byte_q, byte_d;
  logic          trunc_q, trunc_d;

  // Result register
  logic       m_valid_q, m_valid_d;
  logic [7:0] m_byte_q, m_byte_d;
  logic       m_bv_q, m_bv_d;
  logic       m_last_q, m_last_d;
  logic [2:0] m_status_q, m_status_d;

  logic       out_load;
  logic [7:0] o_byte;
  logic       o_bv;
  logic       o_last;
  logic [2:0] o_status;

  assign slot_free     = !m_valid_q || m_axis_tready;
  assign s_axis_tready = (state_q == ES_IDLE) && !setup_stat.busy && slot_free;
  assign s_fire        = s_axis_tvalid && s_axis_tready;

  a2b_setup #(
    .PARAM_STORE_BYTES(PARAM_STORE_BYTES)
  ) u_setup (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .fire_i   (s_fire && !s_axis_tuser),
    .byte_i   (s_axis_tdata),
    .last_i   (s_axis_tlast),
    .wr_en_o  (wr_en),
    .wr_addr_o(wr_addr),
    .wr_data_o(wr_data),
    .plen_o   (plen),
    .stat_o   (setup_stat)
  );

  a2b_pkt u_pkt (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .fire_i(s_fire && s_axis_tuser),
    .byte_i(s_axis_tdata),
    .last_i(s_axis_tlast),
    .res_o (pkt_res)
  );

  a2b_ram #(
    .WIDTH(8),
    .DEPTH(PARAM_STORE_BYTES)
  ) u_store (
    .clk_i  (clk_i),
    .we_i   (wr_en),
    .waddr_i(wr_addr),
    .wdata_i(wr_data),
    .re_i   (rd_en),
    .raddr_i(rd_addr),
    .rdata_o(rd_data)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ES_IDLE;
      m_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      m_valid_q <= m_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q      <= idx_d;
    byte_q     <= byte_d;
    trunc_q    <= trunc_d;
    m_byte_q   <= m_byte_d;
    m_bv_q     <= m_bv_d;
    m_last_q   <= m_last_d;
    m_status_q <= m_status_d;
  end

  assign idx_nxt = LW'(idx_q) + LW'(1);

  // Next state and result selection
  always_comb begin
    state_d  = state_q;
    idx_d    = idx_q;
    byte_d   = byte_q;
    trunc_d  = trunc_q;
    rd_en    = 1'b0;
    rd_addr  = '0;
    out_load = 1'b0;
    o_byte   = 8'h00;
    o_bv     = 1'b1;
    o_last   = 1'b0;
    o_status = ST_OK;

    case (state_q)
      ES_IDLE: begin
        if (s_fire && !s_axis_tuser) begin
          if (setup_stat.has_status) begin
            out_load = 1'b1;
            o_bv     = 1'b0;
            o_last   = 1'b1;
            o_status = setup_stat.status;
          end
        end else if (s_fire) begin
          if (pkt_res.status_only) begin
            out_load = 1'b1;
            o_bv     = 1'b0;
            o_last   = 1'b1;
            o_status = pkt_res.status;
          end else if (pkt_res.emit) begin
            byte_d  = s_axis_tdata;
            trunc_d = pkt_res.trunc;
            if (!pkt_res.first && !pkt_res.trunc) begin
              // plain NAL body byte goes straight out
              out_load = 1'b1;
              o_byte   = s_axis_tdata;
              o_last   = 1'b1;
            end else if (!pkt_res.first) begin
              state_d = ES_DATA;
            end else if ((s_axis_tdata[4:0] == NAL_TYPE_IDR) && setup_stat.param_ready &&
                         (plen != '0)) begin
              rd_en   = 1'b1;
              rd_addr = '0;
              idx_d   = '0;
              state_d = ES_PARAM;
            end else begin
              state_d = ES_SC0;
            end
          end
        end
      end
      ES_PARAM: begin
        if (slot_free) begin
          out_load = 1'b1;
          o_byte   = rd_data;
          if (idx_nxt < plen) begin
            rd_en   = 1'b1;
            rd_addr = idx_nxt[AW-1:0];
            idx_d   = idx_nxt[AW-1:0];
          end else begin
            state_d = ES_SC0;
          end
        end
      end
      ES_SC0: begin
        if (slot_free) begin
          out_load = 1'b1;
          state_d  = ES_SC1;
        end
      end
      ES_SC1: begin
        if (slot_free) begin
          out_load = 1'b1;
          state_d  = ES_SC2;
        end
      end
      ES_SC2: begin
        if (slot_free) begin
          out_load = 1'b1;
          o_byte   = 8'h01;
          state_d  = ES_DATA;
        end
      end
      ES_DATA: begin
        if (slot_free) begin
          out_load = 1'b1;
          o_byte   = byte_q;
          o_last   = !trunc_q;
          state_d  = trunc_q ? ES_TRUNC : ES_IDLE;
        end
      end
      ES_TRUNC: begin
        if (slot_free) begin
          out_load = 1'b1;
          o_bv     = 1'b0;
          o_last   = 1'b1;
          o_status = ST_PKT_TRUNC;
          state_d  = ES_IDLE;
        end
      end
      default: begin
        state_d = ES_IDLE;
      end
    endcase
  end

  // Result register: loads only when the slot is free
  always_comb begin
    m_valid_d  = m_valid_q;
    m_byte_d   = m_byte_q;
    m_bv_d     = m_bv_q;
    m_last_d   = m_last_q;
    m_status_d = m_status_q;
    if (out_load) begin
      m_valid_d  = 1'b1;
      m_byte_d   = o_byte;
      m_bv_d     = o_bv;
      m_last_d   = o_last;
      m_status_d = o_status;
    end else if (m_axis_tready) begin
      m_valid_d  = 1'b0;
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_byte_q;
  assign m_axis_tuser  = {m_status_q, m_bv_q};
  assign m_axis_tlast  = m_last_q;

  // Store replay never runs past the filled part of the store
  a_idx_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ES_PARAM |-> LW'(idx_q) < plen)
    else $error("store replay index beyond stored length");

  // No store write while a replay burst is running
  a_no_write_in_burst: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_en |-> state_q == ES_IDLE)
    else $error("store written during output burst");

  // Stored length never exceeds the store
  a_plen_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    plen <= LW'(PARAM_STORE_BYTES))
    else $error("stored length exceeds store depth");

  // Status-only results are single, zero-byte, run-ending transfers
  a_status_shape: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_valid_q && !m_bv_q |-> m_byte_q == 8'h00 && m_last_q && m_status_q != ST_OK)
    else $error("malformed status transfer");

  // A new burst only starts from an accepted packet byte
  a_burst_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $past(state_q) == ES_IDLE && state_q != ES_IDLE |-> $past(s_fire && s_axis_tuser))
    else $error("burst started without a packet byte");

endmodule

/* dv/a2b_tb_pkg.sv */
// Scoreboard for the AVCC to Annex B converter: stream predictor and result checker.
`timescale 1ns / 1ps
package a2b_tb_pkg;
  import a2b_pkg::*;

  localparam int unsigned STORE_BYTES = PARAM_STORE_BYTES_DEF;

  typedef struct packed {
    logic [7:0] data;
    logic       vld;
    logic       last;
    logic [2:0] status;
  } stream_res_t;

  class annexb_tracker;
    stream_res_t  pending_out[$];
    stream_res_t  step_out[$];
    int unsigned  mismatches;

    // predicted converter state
    logic [7:0]   pstore[STORE_BYTES];
    int unsigned  plen;
    bit           pready;
    setup_phase_e sphase;
    int unsigned  skip_cnt;
    logic [4:0]   units_left;
    logic [15:0]  unit_left;
    bit           in_pps;
    pkt_phase_e   pphase;
    int unsigned  pfx_cnt;
    logic [31:0]  nal_len;
    logic [31:0]  nal_rem;

    function new();
      foreach (pstore[i]) pstore[i] = 8'h00;
      plen       = 0;
      pready     = 1'b0;
      sphase     = SP_SKIP;
      skip_cnt   = 0;
      units_left = '0;
      unit_left  = '0;
      in_pps     = 1'b0;
      mismatches = 0;
      pkt_restart();
    endfunction

    function void emit(logic [7:0] data, logic vld, logic [2:0] status);
      stream_res_t r;
      r.data   = data;
      r.vld    = vld;
      r.last   = 1'b0;
      r.status = status;
      step_out.push_back(r);
    endfunction

    function void store_byte(logic [7:0] b);
      if (plen < STORE_BYTES) begin
        pstore[plen] = b;
        plen++;
      end
    endfunction

    function void unit_done();
      units_left = units_left - 5'd1;
      if (units_left != 0) begin
        sphase = SP_LEN_HI;
      end else if (in_pps) begin
        sphase = SP_DONE;
        pready = 1'b1;
      end else begin
        in_pps = 1'b1;
        sphase = SP_COUNT;
      end
    endfunction

    function void pkt_restart();
      pphase  = PP_LENGTH;
      pfx_cnt = 0;
      nal_len = '0;
      nal_rem = '0;
    endfunction

    function void config_byte(logic [7:0] b, bit last);
      case (sphase)
        SP_SKIP: begin
          // first header byte of a new block drops the old parameter sets
          if (skip_cnt == 0) begin
            plen   = 0;
            pready = 1'b0;
          end
          skip_cnt++;
          if (skip_cnt >= 4) begin
            skip_cnt = 0;
            sphase   = SP_LENSIZE;
          end
        end
        SP_LENSIZE: begin
          in_pps = 1'b0;
          sphase = SP_COUNT;
        end
        SP_COUNT: begin
          units_left = b[4:0] & COUNT_MASK;
          if (units_left != 0) begin
            sphase = SP_LEN_HI;
          end else if (in_pps) begin
            sphase = SP_DONE;
            pready = 1'b1;
          end else begin
            in_pps = 1'b1;
          end
        end
        SP_LEN_HI: begin
          unit_left = {b, 8'h00};
          sphase    = SP_LEN_LO;
        end
        SP_LEN_LO: begin
          unit_left[7:0] = b;
          if (plen + 4 + unit_left > STORE_BYTES) begin
            plen   = 0;
            pready = 1'b0;
            sphase = SP_ERROR;
            emit(8'h00, 1'b0, ST_OVERFLOW);
          end else begin
            store_byte(8'h00);
            store_byte(8'h00);
            store_byte(8'h00);
            store_byte(8'h01);
            if (unit_left == 0) unit_done();
            else sphase = SP_UNIT;
          end
        end
        SP_UNIT: begin
          store_byte(b);
          unit_left = unit_left - 16'd1;
          if (unit_left == 0) unit_done();
        end
        default: ;
      endcase
      if (last) begin
        if (sphase != SP_DONE && sphase != SP_ERROR) begin
          plen   = 0;
          pready = 1'b0;
          emit(8'h00, 1'b0, ST_EXTRA_TRUNC);
        end
        sphase   = SP_SKIP;
        skip_cnt = 0;
      end
    endfunction

    function void packet_byte(logic [7:0] b, bit last);
      if (pphase == PP_LENGTH) begin
        nal_len = {nal_len[23:0], b};
        if (pfx_cnt < 3) begin
          pfx_cnt++;
          if (last) begin
            emit(8'h00, 1'b0, ST_PKT_TRUNC);
            pkt_restart();
          end
        end else begin
          pfx_cnt = 0;
          if (nal_len == 0) begin
            emit(8'h00, 1'b0, ST_BAD_LEN);
            pkt_restart();
            if (!last) pphase = PP_DISCARD;
          end else if (last) begin
            emit(8'h00, 1'b0, ST_PKT_TRUNC);
            pkt_restart();
          end else begin
            nal_rem = nal_len;
            pphase  = PP_NAL;
          end
        end
      end else if (pphase == PP_NAL) begin
        if (nal_rem == nal_len) begin
          // IDR gets the parameter sets replayed ahead of its start code
          if (b[4:0] == NAL_TYPE_IDR && pready) begin
            for (int i = 0; i < plen; i++) emit(pstore[i], 1'b1, ST_OK);
          end
          emit(8'h00, 1'b1, ST_OK);
          emit(8'h00, 1'b1, ST_OK);
          emit(8'h01, 1'b1, ST_OK);
        end
        emit(b, 1'b1, ST_OK);
        nal_rem = nal_rem - 32'd1;
        if (nal_rem == 0) begin
          pkt_restart();
        end else if (last) begin
          emit(8'h00, 1'b0, ST_PKT_TRUNC);
          pkt_restart();
        end
      end else if (last) begin
        pkt_restart();
      end
    endfunction

    // Accepted input transfer: predict its results and queue them.
    function void take_byte(bit is_packet, logic [7:0] b, bit last);
      step_out.delete();
      if (is_packet) packet_byte(b, last);
      else config_byte(b, last);
      if (step_out.size() > 0) step_out[step_out.size() - 1].last = 1'b1;
      foreach (step_out[i]) pending_out.push_back(step_out[i]);
    endfunction

    // Accepted output transfer: compare with the oldest prediction.
    function void match_output(logic [7:0] data, logic [3:0] user, logic last);
      stream_res_t want;
      if (pending_out.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected output: data %h vld %b last %b status %0d",
                   data, user[0], last, user[3:1]);
      end else begin
        want = pending_out.pop_front();
        if (want.data !== data || want.vld !== user[0] || want.last !== last ||
            want.status !== user[3:1]) begin
          mismatches++;
          if (mismatches <= 10)
            $display("output mismatch: exp data %h vld %b last %b status %0d, got %h %b %b %0d",
                     want.data, want.vld, want.last, want.status,
                     data, user[0], last, user[3:1]);
        end
      end
    endfunction
  endclass

endpackage

/* dv/tb_top.sv */
// Testbench top: drives random AVCC extradata and packets, checks the Annex B output.
`timescale 1ns / 1ps
module tb_top;
  import a2b_pkg::*;
  import a2b_tb_pkg::*;

  localparam bit FUNC_EXTRA  = 1'b0;
  localparam bit FUNC_PACKET = 1'b1;
  localparam int ITEM_TARGET = 420;
  localparam int IDLE_LIMIT  = 4000;
  localparam int TAIL_CYCLES = 100;

  typedef enum int {CFG_GOOD, CFG_TRUNC, CFG_BIG, CFG_TRAIL} cfg_kind_e;
  typedef enum int {PKT_GOOD, PKT_ZERO, PKT_CUT, PKT_HUGE} pkt_kind_e;
  typedef enum int {RX_OPEN, RX_COIN, RX_MOSTLY, RX_SLOW} rx_mode_e;

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       s_axis_tvalid = 1'b0;
  logic       s_axis_tready;
  logic [7:0] s_axis_tdata = 8'h00;
  logic       s_axis_tuser = 1'b0;
  logic       s_axis_tlast = 1'b0;
  logic       m_axis_tvalid;
  logic       m_axis_tready = 1'b0;
  logic [7:0] m_axis_tdata;
  logic [3:0] m_axis_tuser;
  logic       m_axis_tlast;

  annexb_tracker tracker;

  logic [7:0] cfg_bytes[$];
  logic [7:0] pkt_bytes[$];
  int         burst_left = 0;
  int         sent_items = 0;
  int         noise_items = 0;
  int         idle_cycles = 0;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  avcc_to_annexb_converter_core u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  // Transfer monitor: both sides sampled at the edge, before any update lands.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready)
        tracker.match_output(m_axis_tdata, m_axis_tuser, m_axis_tlast);
      if (s_axis_tvalid && s_axis_tready)
        tracker.take_byte(s_axis_tuser, s_axis_tdata, s_axis_tlast);
    end
  end

  // Watchdog on cycles without any transfer.
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Receiver back-pressure: a mode is held for a stretch, then a new one is drawn.
  rx_mode_e rx_mode = RX_OPEN;
  int       rx_left = 0;
  int       stall_len = 1;
  int       stall_pos = 0;
  always @(posedge clk_i) begin
    if (rx_left == 0) begin
      rx_mode   = rx_mode_e'($urandom_range(0, 3));
      rx_left   = $urandom_range(20, 300);
      stall_len = $urandom_range(1, 7);
      stall_pos = 0;
    end else begin
      rx_left--;
    end
    case (rx_mode)
      RX_OPEN:   m_axis_tready <= 1'b1;
      RX_COIN:   m_axis_tready <= 1'($urandom_range(0, 1));
      RX_MOSTLY: m_axis_tready <= ($urandom_range(0, 9) != 0);
      default: begin
        // one ready cycle, then stalled until stall_pos wraps past stall_len
        m_axis_tready <= (stall_pos == 0);
        stall_pos = (stall_pos >= stall_len) ? 0 : stall_pos + 1;
      end
    endcase
  end

  // One input transfer; the sender idles between bursts. Called right after an edge.
  task automatic send_byte(bit func, logic [7:0] b, bit last);
    if (burst_left == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(50, 150) : $urandom_range(1, 12);
    end
    burst_left--;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    s_axis_tuser  <= func;
    s_axis_tlast  <= last;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    sent_items++;
  endtask

  // Sender holds off until every predicted result has come out.
  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (tracker.pending_out.size() != 0) @(posedge clk_i);
  endtask

  // Sends the queued extradata and packet bytes, interleaved at random when both are present.
  task automatic send_runs();
    int ci;
    int pi;
    bit pick_pkt;
    ci = 0;
    pi = 0;
    while (ci < cfg_bytes.size() || pi < pkt_bytes.size()) begin
      if (ci >= cfg_bytes.size()) pick_pkt = 1'b1;
      else if (pi >= pkt_bytes.size()) pick_pkt = 1'b0;
      else pick_pkt = 1'($urandom_range(0, 1));
      if (pick_pkt) begin
        send_byte(FUNC_PACKET, pkt_bytes[pi], pi == pkt_bytes.size() - 1);
        pi++;
      end else begin
        send_byte(FUNC_EXTRA, cfg_bytes[ci], ci == cfg_bytes.size() - 1);
        ci++;
      end
    end
    cfg_bytes.delete();
    pkt_bytes.delete();
  endtask

  // Extradata record: header, length-size byte, SPS list, PPS list.
  task automatic make_config(cfg_kind_e kind);
    int n;
    int len;
    int cut;
    cfg_bytes.delete();
    repeat (5) cfg_bytes.push_back(8'($urandom));
    for (int part = 0; part < 2; part++) begin
      if (kind == CFG_BIG && $urandom_range(0, 5) == 0) n = $urandom_range(4, 31);
      else n = $urandom_range(0, 3);
      cfg_bytes.push_back({3'($urandom), 5'(n)});
      for (int u = 0; u < n && u < 6; u++) begin
        if (kind == CFG_BIG)
          len = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 65535) : $urandom_range(8, 30);
        else
          len = $urandom_range(0, 6);
        cfg_bytes.push_back(8'(len >> 8));
        cfg_bytes.push_back(8'(len));
        // oversized units overflow the store; their bodies need not be sent in full
        for (int i = 0; i < len && i < 32; i++) cfg_bytes.push_back(8'($urandom));
      end
    end
    if (kind == CFG_TRAIL) repeat ($urandom_range(1, 4)) cfg_bytes.push_back(8'($urandom));
    if (kind == CFG_TRUNC && cfg_bytes.size() > 1) begin
      cut = $urandom_range(1, cfg_bytes.size() - 1);
      while (cfg_bytes.size() > cut) void'(cfg_bytes.pop_back());
    end
  endtask

  // Packet of length-prefixed NALs, with the error shapes selected by kind.
  task automatic make_packet(pkt_kind_e kind);
    int nals;
    int len;
    int cut;
    logic [31:0] big;
    pkt_bytes.delete();
    if (kind == PKT_HUGE) begin
      big = $urandom;
      if (big[31:24] == 8'h00) big[31:24] = 8'($urandom_range(1, 255));
      for (int i = 3; i >= 0; i--) pkt_bytes.push_back(big[i*8 +: 8]);
      repeat ($urandom_range(0, 5)) pkt_bytes.push_back(8'($urandom));
    end else begin
      nals = $urandom_range(1, 3);
      for (int k = 0; k < nals; k++) begin
        if (kind == PKT_ZERO && k == nals - 1) begin
          repeat (4) pkt_bytes.push_back(8'h00);
          repeat ($urandom_range(0, 3)) pkt_bytes.push_back(8'($urandom));
        end else begin
          len = ($urandom_range(0, 7) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 12);
          for (int i = 3; i >= 0; i--) pkt_bytes.push_back(8'(len >> (i * 8)));
          if ($urandom_range(0, 1)) pkt_bytes.push_back({3'($urandom), NAL_TYPE_IDR});
          else pkt_bytes.push_back(8'($urandom));
          repeat (len - 1) pkt_bytes.push_back(8'($urandom));
        end
      end
    end
    if (kind == PKT_CUT && pkt_bytes.size() > 1) begin
      cut = $urandom_range(1, pkt_bytes.size() - 1);
      while (pkt_bytes.size() > cut) void'(pkt_bytes.pop_back());
    end
  endtask

  initial begin
    int pick;
    bit paused;
    tracker = new();
    paused  = 1'b0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: one SPS and one PPS, an IDR that replays them, then a zero-length NAL.
    cfg_bytes = '{8'h01, 8'h64, 8'h00, 8'hFF, 8'hFF,
                  8'hE1, 8'h00, 8'h02, 8'h67, 8'hFF,
                  8'h01, 8'h00, 8'h01, 8'h00};
    send_runs();
    pkt_bytes = '{8'h00, 8'h00, 8'h00, 8'h02, 8'h65, 8'h80};
    send_runs();
    pkt_bytes = '{8'h00, 8'h00, 8'h00, 8'h00, 8'hFF};
    send_runs();
    wait_drained();

    // Random: mostly well-formed records and packets, some broken ones and some noise.
    while (sent_items - noise_items < ITEM_TARGET) begin
      if (!paused && sent_items > 230) begin
        wait_drained();
        paused = 1'b1;
      end
      pick = $urandom_range(0, 99);
      if (pick < 20) begin
        make_config(cfg_kind_e'(($urandom_range(0, 9) < 6) ? CFG_GOOD : $urandom_range(1, 3)));
        send_runs();
      end else if (pick < 85) begin
        make_packet(pkt_kind_e'(($urandom_range(0, 3) != 0) ? PKT_GOOD : $urandom_range(1, 3)));
        send_runs();
      end else if (pick < 95) begin
        make_config(CFG_GOOD);
        make_packet(pkt_kind_e'($urandom_range(0, 3)));
        send_runs();
      end else begin
        repeat ($urandom_range(1, 6)) begin
          send_byte(1'($urandom), 8'($urandom), 1'($urandom));
          noise_items++;
        end
      end
    end

    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (tracker.mismatches == 0 && tracker.pending_out.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
